// File: src/kvhw_pkg.sv
// Shared types, codes and constant tables for the key/value header walker.
// Used by every module of the block; depends on nothing.
`default_nettype none
package kvhw_pkg;

  localparam int OFF_BITS = 48;

  typedef enum logic [10:0] {
    PH_SKIP   = 11'd1,
    PH_COUNT  = 11'd2,
    PH_KLEN   = 11'd4,
    PH_KEY    = 11'd8,
    PH_VTYPE  = 11'd16,
    PH_ATYPE  = 11'd32,
    PH_ACOUNT = 11'd64,
    PH_SLEN   = 11'd128,
    PH_SBODY  = 11'd256,
    PH_FIXED  = 11'd512,
    PH_IDLE   = 11'd1024
  } phase_t;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_CAP   = 2'd0;
  localparam logic [1:0] ERR_VTYPE = 2'd1;
  localparam logic [1:0] ERR_ETYPE = 2'd2;

  localparam logic [3:0] TYPE_STRING = 4'd8;
  localparam logic [3:0] TYPE_ARRAY  = 4'd9;
  localparam logic [63:0] TYPE_LAST  = 64'd12;

  // Key names, left aligned in 32 bytes.
  localparam logic [255:0] TOK_NAME0 = {"tokenizer.gg", "ml.tokens", 88'd0};
  localparam logic [255:0] TOK_NAME1 = {"tokenizer.gg", "ml.merges", 88'd0};
  localparam logic [255:0] TOK_NAME2 = {"tokenizer.gg", "ml.tok", "en_type", 56'd0};
  localparam logic [4:0] TOK_LEN0 = 5'd21;
  localparam logic [4:0] TOK_LEN1 = 5'd21;
  localparam logic [4:0] TOK_LEN2 = 5'd25;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [15:0] entry_number;
    logic [47:0] entry_start;
    logic [47:0] value_start;
    logic [47:0] entry_end;
    logic [3:0]  value_type;
    logic [3:0]  element_type;
    logic [63:0] element_count;
    logic        tokenizer_key;
    logic        last;
  } rec_t;

  function automatic logic [3:0] type_size(input logic [3:0] t);
    case (t)
      4'd0, 4'd1, 4'd7:   type_size = 4'd1;
      4'd2, 4'd3:         type_size = 4'd2;
      4'd4, 4'd5, 4'd6:   type_size = 4'd4;
      4'd8, 4'd9:         type_size = 4'd0;
      4'd10, 4'd11, 4'd12: type_size = 4'd8;
      default:            type_size = 4'd1;
    endcase
  endfunction

  function automatic logic [7:0] tok_byte(input logic [1:0] which, input logic [4:0] pos);
    logic [4:0] k;
    k = 5'd31 - pos;
    case (which)
      2'd0:    tok_byte = TOK_NAME0[{k, 3'b000} +: 8];
      2'd1:    tok_byte = TOK_NAME1[{k, 3'b000} +: 8];
      default: tok_byte = TOK_NAME2[{k, 3'b000} +: 8];
    endcase
  endfunction

  function automatic logic [4:0] tok_len(input logic [1:0] which);
    case (which)
      2'd0:    tok_len = TOK_LEN0;
      2'd1:    tok_len = TOK_LEN1;
      default: tok_len = TOK_LEN2;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: src/kvhw_front.sv
// Front part: a two-word input queue that takes header bytes from the producer.
// Depends on kvhw_pkg for the item type.
`default_nettype none
module kvhw_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire kvhw_pkg::in_item_t wr_item,
  output logic                   rd_valid,
  output kvhw_pkg::in_item_t     rd_item,
  input  wire logic              rd_take
);
  import kvhw_pkg::*;

  in_item_t   mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;

  assign full     = (count == 2'd2);
  assign do_push  = push && !full;
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (rd_take) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, rd_take};
    end
  end
endmodule
`default_nettype wire

// File: src/kvhw_walker.sv
// Back part: walks the header one byte per cycle while out_space is high and builds up to two result words.
// Depends on kvhw_pkg for phases, codes, records and key tables.
`default_nettype none
module kvhw_walker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire kvhw_pkg::in_item_t in_item,
  output logic                    in_take,
  input  wire logic               out_space,
  input  wire logic [15:0]        max_entries,
  output logic                    r0_valid,
  output kvhw_pkg::rec_t          r0,
  output logic                    r1_valid,
  output kvhw_pkg::rec_t          r1
);
  import kvhw_pkg::*;

  phase_t              phase, phase_next, e_phase;
  logic [3:0]          fbc, fbc_next, e_fbc;
  logic [63:0]         asm_reg, asm_next, e_asm;
  logic [OFF_BITS-1:0] off, e_off, end_off;
  logic [63:0]         entries, entries_next, e_entries;
  logic [15:0]         idx, idx_next, e_idx;
  logic [OFF_BITS-1:0] hes, hes_next, e_hes;
  logic [OFF_BITS-1:0] hvs, hvs_next, e_hvs;
  logic [7:0]          htypes, htypes_next, e_htypes;
  logic [63:0]         hcount, hcount_next, e_hcount;
  logic [63:0]         elems, elems_next, e_elems;
  logic [63:0]         bleft, bleft_next, e_bleft;
  logic [2:0]          nm, nm_next, e_nm;
  logic [63:0]         klen, klen_next, e_klen;
  logic [4:0]          kpos, kpos_next, e_kpos;

  logic [3:0]  cnt1;
  logic [63:0] asm_v;
  logic [63:0] bl_dec;
  logic [63:0] el_dec;
  logic [63:0] ent_dec;
  logic        do_elem, do_start, do_entry;

  assign in_take = in_valid && out_space;

  // A byte marked first restarts the walk before it is looked at.
  always_comb begin
    if (in_item.first) begin
      e_phase = PH_SKIP;  e_fbc = '0;  e_asm = '0;  e_off = '0;
      e_entries = '0;  e_idx = '0;  e_hes = '0;  e_hvs = '0;  e_htypes = '0;
      e_hcount = '0;  e_elems = '0;  e_bleft = '0;  e_nm = 3'b111;
      e_klen = '0;  e_kpos = '0;
    end else begin
      e_phase = phase;  e_fbc = fbc;  e_asm = asm_reg;  e_off = off;
      e_entries = entries;  e_idx = idx;  e_hes = hes;  e_hvs = hvs;
      e_htypes = htypes;  e_hcount = hcount;  e_elems = elems;  e_bleft = bleft;
      e_nm = nm;  e_klen = klen;  e_kpos = kpos;
    end
  end

  assign cnt1    = {1'b0, e_fbc[2:0]} + 4'd1;
  assign asm_v   = e_asm | ({56'd0, in_item.data} << {e_fbc[2:0], 3'b000});
  assign end_off = e_off + OFF_BITS'(1);
  assign bl_dec  = e_bleft - 64'd1;

  always_comb begin
    phase_next = e_phase;  fbc_next = e_fbc;  asm_next = e_asm;
    entries_next = e_entries;  idx_next = e_idx;  hes_next = e_hes;
    hvs_next = e_hvs;  htypes_next = e_htypes;  hcount_next = e_hcount;
    elems_next = e_elems;  bleft_next = e_bleft;  nm_next = e_nm;
    klen_next = e_klen;  kpos_next = e_kpos;
    r0 = '0;  r1 = '0;  r0_valid = 1'b0;  r1_valid = 1'b0;
    do_elem = 1'b0;  do_start = 1'b0;  do_entry = 1'b0;
    el_dec = '0;  ent_dec = '0;

    case (e_phase)
      PH_SKIP: begin
        if (e_off == OFF_BITS'(15)) phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        if (cnt1 == 4'd8) begin
          fbc_next = '0;
          asm_next = '0;
          if (asm_v > {48'd0, max_entries}) begin
            r0_valid = 1'b1;
            r0.kind = KIND_ERROR;
            r0.error_code = ERR_CAP;
            r0.entry_number = e_idx;
            phase_next = PH_IDLE;
          end else if (asm_v == 64'd0) begin
            r0_valid = 1'b1;
            r0.kind = KIND_DONE;
            phase_next = PH_IDLE;
          end else begin
            entries_next = asm_v;
            idx_next = '0;
            hes_next = end_off;
            nm_next = 3'b111;
            phase_next = PH_KLEN;
          end
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_KLEN: begin
        if (cnt1 == 4'd8) begin
          fbc_next = '0;
          asm_next = '0;
          klen_next = asm_v;
          bleft_next = asm_v;
          kpos_next = '0;
          if (asm_v == 64'd0) begin
            nm_next = 3'b000;
            phase_next = PH_VTYPE;
          end else begin
            nm_next = 3'b111;
            phase_next = PH_KEY;
          end
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_KEY: begin
        for (int t = 0; t < 3; t++) begin
          if (e_nm[t] && ((e_kpos >= tok_len(2'(t))) ||
                          (tok_byte(2'(t), e_kpos) != in_item.data))) begin
            nm_next[t] = 1'b0;
          end
        end
        if (e_kpos != 5'd31) kpos_next = e_kpos + 5'd1;
        bleft_next = bl_dec;
        if (bl_dec == 64'd0) begin
          for (int t = 0; t < 3; t++) begin
            if (e_klen != {59'd0, tok_len(2'(t))}) nm_next[t] = 1'b0;
          end
          phase_next = PH_VTYPE;
        end
      end
      PH_VTYPE: begin
        if (cnt1 == 4'd4) begin
          fbc_next = '0;
          asm_next = '0;
          hvs_next = end_off;
          hcount_next = '0;
          if (asm_v > TYPE_LAST) begin
            htypes_next = '0;
            r0_valid = 1'b1;
            r0.kind = KIND_ERROR;
            r0.error_code = ERR_VTYPE;
            r0.entry_number = e_idx;
            phase_next = PH_IDLE;
          end else begin
            htypes_next = {4'd0, asm_v[3:0]};
            if (asm_v[3:0] == TYPE_ARRAY) begin
              phase_next = PH_ATYPE;
            end else if (asm_v[3:0] == TYPE_STRING) begin
              phase_next = PH_SLEN;
            end else begin
              phase_next = PH_FIXED;
              bleft_next = {60'd0, type_size(asm_v[3:0])};
            end
          end
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_ATYPE: begin
        if (cnt1 == 4'd4) begin
          fbc_next = '0;
          asm_next = '0;
          if (asm_v > TYPE_LAST) begin
            r0_valid = 1'b1;
            r0.kind = KIND_ERROR;
            r0.error_code = ERR_ETYPE;
            r0.entry_number = e_idx;
            phase_next = PH_IDLE;
          end else begin
            htypes_next = {asm_v[3:0], e_htypes[3:0]};
            phase_next = PH_ACOUNT;
          end
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_ACOUNT: begin
        if (cnt1 == 4'd8) begin
          fbc_next = '0;
          asm_next = '0;
          hcount_next = asm_v;
          elems_next = asm_v;
          if (asm_v == 64'd0 || e_htypes[7:4] == TYPE_ARRAY) do_entry = 1'b1;
          else do_start = 1'b1;
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_SLEN: begin
        if (cnt1 == 4'd8) begin
          fbc_next = '0;
          asm_next = '0;
          bleft_next = asm_v;
          if (asm_v == 64'd0) do_elem = 1'b1;
          else phase_next = PH_SBODY;
        end else begin
          fbc_next = cnt1;
          asm_next = asm_v;
        end
      end
      PH_SBODY, PH_FIXED: begin
        bleft_next = bl_dec;
        if (bl_dec == 64'd0) do_elem = 1'b1;
      end
      default: begin
      end
    endcase

    // One string or fixed element has ended; arrays count down their elements.
    if (do_elem) begin
      if (htypes_next[3:0] == TYPE_ARRAY) begin
        el_dec = e_elems - 64'd1;
        elems_next = el_dec;
        if (el_dec == 64'd0) do_entry = 1'b1;
        else do_start = 1'b1;
      end else begin
        do_entry = 1'b1;
      end
    end

    if (do_start) begin
      if (htypes_next[7:4] == TYPE_STRING) begin
        phase_next = PH_SLEN;
      end else begin
        phase_next = PH_FIXED;
        bleft_next = {60'd0, type_size(htypes_next[7:4])};
      end
    end

    if (do_entry) begin
      r0_valid = 1'b1;
      r0.kind = KIND_ENTRY;
      r0.entry_number = e_idx;
      r0.entry_start = e_hes;
      r0.value_start = e_hvs;
      r0.entry_end = end_off;
      r0.value_type = htypes_next[3:0];
      r0.element_type = htypes_next[7:4];
      r0.element_count = hcount_next;
      r0.tokenizer_key = (nm_next != 3'b000);
      idx_next = e_idx + 16'd1;
      ent_dec = e_entries - 64'd1;
      entries_next = ent_dec;
      if (ent_dec == 64'd0) begin
        r1_valid = 1'b1;
        r1.kind = KIND_DONE;
        r1.entry_number = idx_next;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_KLEN;
        hes_next = end_off;
        nm_next = 3'b111;
      end
    end

    r0.last = !r1_valid;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;  fbc <= '0;  asm_reg <= '0;  off <= '0;
      entries <= '0;  idx <= '0;  hes <= '0;  hvs <= '0;  htypes <= '0;
      hcount <= '0;  elems <= '0;  bleft <= '0;  nm <= 3'b111;
      klen <= '0;  kpos <= '0;
    end else if (in_take) begin
      phase <= phase_next;  fbc <= fbc_next;  asm_reg <= asm_next;  off <= end_off;
      entries <= entries_next;  idx <= idx_next;  hes <= hes_next;  hvs <= hvs_next;
      htypes <= htypes_next;  hcount <= hcount_next;  elems <= elems_next;
      bleft <= bleft_next;  nm <= nm_next;  klen <= klen_next;  kpos <= kpos_next;
    end
  end

  // A second word in one cycle is always the finish that follows the last entry.
  a_second_is_done: assert property (@(posedge clk) disable iff (rst)
    r1_valid |-> (r0_valid && r0.kind == KIND_ENTRY && r1.kind == KIND_DONE))
    else $error("second result word is not a finish after an entry");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (in_take && r0_valid && r0.kind != KIND_ENTRY) |=> (phase == PH_IDLE))
    else $error("walker did not stop after finish or error");

  a_field_count: assert property (@(posedge clk) disable iff (rst)
    fbc <= 4'd7)
    else $error("field byte count out of range");
endmodule
`default_nettype wire

// File: src/kvhw_result_queue.sv
// Result queue: four words, up to two written per cycle, one read per cycle.
// Depends on kvhw_pkg for the result record type.
`default_nettype none
module kvhw_result_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr0_valid,
  input  wire kvhw_pkg::rec_t wr0,
  input  wire logic           wr1_valid,
  input  wire kvhw_pkg::rec_t wr1,
  input  wire logic           pop,
  output logic                empty,
  output logic                space2,
  output kvhw_pkg::rec_t      head
);
  import kvhw_pkg::*;

  rec_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       do_pop;

  assign empty  = (count == 3'd0);
  assign space2 = (count <= 3'd2);
  assign do_pop = pop && !empty;
  assign head   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr0_valid) mem[wp] <= wr0;
    if (wr1_valid) mem[wp + 2'd1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + {1'b0, wr0_valid} + {1'b0, wr1_valid};
      rp    <= rp + {1'b0, do_pop};
      count <= count + {2'b0, wr0_valid} + {2'b0, wr1_valid} - {2'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

// File: src/kv_header_walker.sv
// Top level of the key/value header walker: input queue, walker and result queue.
// Depends on kvhw_pkg, kvhw_front, kvhw_walker and kvhw_result_queue.
//
// Usage: header bytes enter through push/full with data_byte and first_byte;
// first_byte high marks offset zero and restarts the walk. Result words leave
// through empty/pop; while empty is low the oldest word is on the result ports.
// Each byte causes zero, one or two words (an entry record, a finish, an error);
// last marks the final word of a byte. The cap register max_entries is written
// through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// Flow: an accepted byte is registered in the input queue; the walker handles
// it combinationally and, when it takes the byte, writes its words into the
// registered result queue, whose count then rises and takes empty low.
// Throughput: one byte per cycle, set by the walker taking one byte a cycle; it
// takes a byte only while the four-word result queue has two free places.
// When the receiver stalls, the result queue fills, the walker holds and the
// input queue raises full after at most two more bytes.
// Reset clears both queues and the walk state and sets max_entries to 64.
`default_nettype none
module kv_header_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [1:0]       error_code,
  output logic [15:0]      entry_number,
  output logic [47:0]      entry_start,
  output logic [47:0]      value_start,
  output logic [47:0]      entry_end,
  output logic [3:0]       value_type,
  output logic [3:0]       element_type,
  output logic [63:0]      element_count,
  output logic             tokenizer_key,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import kvhw_pkg::*;

  in_item_t    wr_item;
  in_item_t    rd_item;
  logic        rd_valid;
  logic        rd_take;
  logic        space2;
  logic        r0_valid;
  logic        r1_valid;
  rec_t        r0;
  rec_t        r1;
  rec_t        head;
  logic [15:0] max_entries;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 16'd64;
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  assign wr_item.first = first_byte;
  assign wr_item.data  = data_byte;

  kvhw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_item  (rd_item),
    .rd_take  (rd_take)
  );

  kvhw_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rd_valid),
    .in_item     (rd_item),
    .in_take     (rd_take),
    .out_space   (space2),
    .max_entries (max_entries),
    .r0_valid    (r0_valid),
    .r0          (r0),
    .r1_valid    (r1_valid),
    .r1          (r1)
  );

  kvhw_result_queue u_results (
    .clk       (clk),
    .rst       (rst),
    .wr0_valid (r0_valid && rd_take),
    .wr0       (r0),
    .wr1_valid (r1_valid && rd_take),
    .wr1       (r1),
    .pop       (pop),
    .empty     (empty),
    .space2    (space2),
    .head      (head)
  );

  assign kind          = head.kind;
  assign error_code    = head.error_code;
  assign entry_number  = head.entry_number;
  assign entry_start   = head.entry_start;
  assign value_start   = head.value_start;
  assign entry_end     = head.entry_end;
  assign value_type    = head.value_type;
  assign element_type  = head.element_type;
  assign element_count = head.element_count;
  assign tokenizer_key = head.tokenizer_key;
  assign last          = head.last;
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for kv_header_walker: streams model-file headers byte by byte,
// predicts every result word from its own walker model and checks the words in order.
// Depends on kvhw_pkg and kv_header_walker.
`default_nettype none
module tb;
  import kvhw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } hdr_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'd0;
  logic        first_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [15:0] entry_number;
  logic [47:0] entry_start;
  logic [47:0] value_start;
  logic [47:0] entry_end;
  logic [3:0]  value_type;
  logic [3:0]  element_type;
  logic [63:0] element_count;
  logic        tokenizer_key;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  kv_header_walker dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .first_byte(first_byte), .empty(empty), .pop(pop), .kind(kind),
    .error_code(error_code), .entry_number(entry_number), .entry_start(entry_start),
    .value_start(value_start), .entry_end(entry_end), .value_type(value_type),
    .element_type(element_type), .element_count(element_count),
    .tokenizer_key(tokenizer_key), .last(last), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  hdr_byte_t pending_bytes[$];
  rec_t      expected_words[$];
  int        mismatches = 0;
  int        words_seen = 0;
  bit        idling_on = 1'b1;

  // Walker model state.
  logic [7:0]  elem_size [13] = '{1, 1, 2, 2, 4, 4, 4, 1, 0, 0, 8, 8, 8};
  logic [15:0] cap_entries = 16'd64;
  phase_t      walk_phase = PH_SKIP;
  int          field_cnt;
  logic [63:0] shift_acc;
  logic [47:0] byte_off;
  logic [63:0] entries_todo;
  logic [15:0] entry_idx;
  logic [47:0] cur_entry_start;
  logic [47:0] cur_value_start;
  logic [7:0]  cur_types;
  logic [63:0] cur_count;
  logic [63:0] elems_todo;
  logic [63:0] bytes_todo;
  logic [2:0]  name_hits;
  logic [63:0] key_len;
  rec_t        step_words[$];

  function automatic string tok_key(input int t);
    string s;
    case (t)
      0:       s = {"tokenizer.gg", "ml.tokens"};
      1:       s = {"tokenizer.gg", "ml.merges"};
      default: s = {"tokenizer.gg", "ml.tok", "en_type"};
    endcase
    return s;
  endfunction

  task automatic restart_walk();
    walk_phase = PH_SKIP; field_cnt = 0; shift_acc = '0; byte_off = '0;
    entries_todo = '0; entry_idx = '0; cur_entry_start = '0; cur_value_start = '0;
    cur_types = '0; cur_count = '0; elems_todo = '0; bytes_todo = '0;
    name_hits = 3'b111; key_len = '0;
  endtask

  function automatic bit gather(input logic [7:0] b, input int n, output logic [63:0] v);
    int c;
    c = field_cnt & 7;
    shift_acc = shift_acc | (64'(b) << (8 * c));
    c++;
    v = shift_acc;
    if (c >= n) begin
      shift_acc = '0;
      field_cnt = 0;
      return 1'b1;
    end
    field_cnt = c;
    return 1'b0;
  endfunction

  task automatic raise_error(input logic [1:0] code);
    rec_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.entry_number = entry_idx;
    step_words.push_back(r);
    walk_phase = PH_IDLE;
  endtask

  task automatic close_entry(input logic [47:0] off);
    rec_t r;
    logic [47:0] end_off;
    end_off = off + 48'd1;
    r = '0;
    r.kind = KIND_ENTRY;
    r.entry_number = entry_idx;
    r.entry_start = cur_entry_start;
    r.value_start = cur_value_start;
    r.entry_end = end_off;
    r.value_type = cur_types[3:0];
    r.element_type = cur_types[7:4];
    r.element_count = cur_count;
    r.tokenizer_key = |name_hits;
    step_words.push_back(r);
    entry_idx = entry_idx + 16'd1;
    entries_todo = entries_todo - 64'd1;
    if (entries_todo == 0) begin
      r = '0;
      r.kind = KIND_DONE;
      r.entry_number = entry_idx;
      step_words.push_back(r);
      walk_phase = PH_IDLE;
    end else begin
      walk_phase = PH_KLEN;
      cur_entry_start = end_off;
      name_hits = 3'b111;
    end
  endtask

  task automatic next_element();
    if (cur_types[7:4] == TYPE_STRING) begin
      walk_phase = PH_SLEN;
    end else begin
      walk_phase = PH_FIXED;
      bytes_todo = 64'(elem_size[cur_types[7:4]]);
    end
  endtask

  task automatic close_element(input logic [47:0] off);
    if (cur_types[3:0] == TYPE_ARRAY) begin
      elems_todo = elems_todo - 64'd1;
      if (elems_todo == 0) close_entry(off);
      else next_element();
    end else begin
      close_entry(off);
    end
  endtask

  // Advances the model by one header byte and queues the words it causes.
  task automatic walk_byte(input logic [7:0] b, input logic fb);
    logic [63:0] v;
    logic [63:0] pos;
    logic [47:0] off;
    string nm;
    rec_t r;
    step_words = {};
    if (fb) restart_walk();
    off = byte_off;
    case (walk_phase)
      PH_SKIP: if (off == 48'd15) walk_phase = PH_COUNT;
      PH_COUNT: if (gather(b, 8, v)) begin
        if (v > 64'(cap_entries)) begin
          raise_error(ERR_CAP);
        end else if (v == 0) begin
          r = '0;
          r.kind = KIND_DONE;
          step_words.push_back(r);
          walk_phase = PH_IDLE;
        end else begin
          entries_todo = v;
          entry_idx = '0;
          cur_entry_start = off + 48'd1;
          name_hits = 3'b111;
          walk_phase = PH_KLEN;
        end
      end
      PH_KLEN: if (gather(b, 8, v)) begin
        key_len = v;
        bytes_todo = v;
        if (v == 0) begin
          name_hits = 3'b000;
          walk_phase = PH_VTYPE;
        end else begin
          name_hits = 3'b111;
          walk_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        pos = key_len - bytes_todo;
        for (int t = 0; t < 3; t++) begin
          nm = tok_key(t);
          if (name_hits[t]) begin
            if (pos >= 64'(nm.len())) name_hits[t] = 1'b0;
            else if (nm.getc(int'(pos)) != b) name_hits[t] = 1'b0;
          end
        end
        bytes_todo = bytes_todo - 64'd1;
        if (bytes_todo == 0) begin
          for (int t = 0; t < 3; t++) begin
            nm = tok_key(t);
            if (key_len != 64'(nm.len())) name_hits[t] = 1'b0;
          end
          walk_phase = PH_VTYPE;
        end
      end
      PH_VTYPE: if (gather(b, 4, v)) begin
        cur_value_start = off + 48'd1;
        cur_count = '0;
        if (v > TYPE_LAST) begin
          cur_types = '0;
          raise_error(ERR_VTYPE);
        end else begin
          cur_types = v[7:0];
          if (v[3:0] == TYPE_ARRAY) walk_phase = PH_ATYPE;
          else if (v[3:0] == TYPE_STRING) walk_phase = PH_SLEN;
          else begin
            walk_phase = PH_FIXED;
            bytes_todo = 64'(elem_size[v[3:0]]);
          end
        end
      end
      PH_ATYPE: if (gather(b, 4, v)) begin
        if (v > TYPE_LAST) begin
          raise_error(ERR_ETYPE);
        end else begin
          cur_types[7:4] = v[3:0];
          walk_phase = PH_ACOUNT;
        end
      end
      PH_ACOUNT: if (gather(b, 8, v)) begin
        cur_count = v;
        elems_todo = v;
        if (v == 0 || cur_types[7:4] == TYPE_ARRAY) close_entry(off);
        else next_element();
      end
      PH_SLEN: if (gather(b, 8, v)) begin
        bytes_todo = v;
        if (v == 0) close_element(off);
        else walk_phase = PH_SBODY;
      end
      PH_SBODY, PH_FIXED: begin
        bytes_todo = bytes_todo - 64'd1;
        if (bytes_todo == 0) close_element(off);
      end
      default: ;
    endcase
    byte_off = off + 48'd1;
    foreach (step_words[i]) begin
      r = step_words[i];
      r.last = (i == step_words.size() - 1);
      expected_words.push_back(r);
    end
  endtask

  // Header generation.
  task automatic put(input logic [7:0] b, input logic f = 1'b0);
    hdr_byte_t h;
    h.data = b;
    h.first = f;
    pending_bytes.push_back(h);
  endtask

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) put(v[8 * i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) put(8'($urandom));
  endtask

  task automatic put_str(input string s);
    put_le(64'(s.len()), 8);
    for (int i = 0; i < s.len(); i++) put(s.getc(i));
  endtask

  task automatic put_head(input logic [63:0] count);
    put(8'($urandom), 1'b1);
    put_rand(15);
    put_le(count, 8);
  endtask

  task automatic put_element(input int et);
    int ln;
    if (et == TYPE_STRING) begin
      ln = $urandom_range(0, 5);
      put_le(64'(ln), 8);
      put_rand(ln);
    end else begin
      put_rand(int'(elem_size[et]));
    end
  endtask

  // One random entry; aborted is set when the entry carries a bad type word.
  task automatic put_entry(output bit aborted);
    int kc, ln, et, cnt, vt, p;
    string nm;
    logic [63:0] c64;
    aborted = 1'b0;
    kc = $urandom_range(0, 9);
    if (kc < 3) begin
      put_str(tok_key(kc));
    end else if (kc == 3) begin
      // Near miss: one byte short, one byte long, or one byte altered.
      nm = tok_key($urandom_range(0, 2));
      ln = nm.len() - 1 + $urandom_range(0, 2);
      p = $urandom_range(0, nm.len() - 1);
      put_le(64'(ln), 8);
      for (int i = 0; i < ln; i++) begin
        if (i >= nm.len()) put("s");
        else if (ln == nm.len() && i == p) put(nm.getc(i) ^ 8'h01);
        else put(nm.getc(i));
      end
    end else begin
      ln = $urandom_range(0, 6);
      put_le(64'(ln), 8);
      put_rand(ln);
    end
    if ($urandom_range(0, 24) == 0) begin
      put_le($urandom_range(0, 1) ? 64'($urandom_range(13, 15)) : 64'($urandom | 32'h100), 4);
      aborted = 1'b1;
      return;
    end
    vt = $urandom_range(0, 12);
    put_le(64'(vt), 4);
    if (vt == TYPE_STRING) begin
      put_element(TYPE_STRING);
    end else if (vt == TYPE_ARRAY) begin
      if ($urandom_range(0, 11) == 0) begin
        put_le($urandom_range(0, 1) ? 64'($urandom_range(13, 15)) : 64'($urandom | 32'h10000), 4);
        aborted = 1'b1;
        return;
      end
      et = $urandom_range(0, 12);
      put_le(64'(et), 4);
      cnt = $urandom_range(0, 4);
      // Nested arrays take no bytes, so their count may be anything.
      c64 = (et == TYPE_ARRAY) ? {$urandom, $urandom} : 64'(cnt);
      put_le(c64, 8);
      if (et != TYPE_ARRAY) for (int i = 0; i < cnt; i++) put_element(et);
    end else begin
      put_element(vt);
    end
  endtask

  task automatic put_header();
    int r, n;
    bit aborted;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      put_head(64'd0);
    end else if (r == 1) begin
      put_head($urandom_range(0, 1) ? 64'(cap_entries) + $urandom_range(1, 3)
                                     : {$urandom, $urandom} | 64'h1_0000_0000);
    end else begin
      n = $urandom_range(1, 5);
      put_head(64'(n));
      for (int i = 0; i < n; i++) begin
        // Now and then the header is cut short and the next one restarts the walk.
        if ($urandom_range(0, 19) == 0) break;
        put_entry(aborted);
        if (aborted) break;
      end
    end
    put_rand($urandom_range(0, 3));
  endtask

  task automatic put_directed();
    put_head(64'd0);
    put_head(64'd7);
    put_str(tok_key(0)); put_le(64'd0, 4); put(8'hff);
    put_str(tok_key(1)); put_le(64'(TYPE_STRING), 4); put_le(64'd0, 8);
    put_str(tok_key(2)); put_le(64'(TYPE_ARRAY), 4); put_le(64'(TYPE_STRING), 4);
    put_le(64'd0, 8);
    put_le(64'd0, 8); put_le(64'(TYPE_ARRAY), 4); put_le(64'(TYPE_ARRAY), 4);
    put_le(64'hffff_ffff_ffff_ffff, 8);
    put_str("k"); put_le(64'(TYPE_ARRAY), 4); put_le(64'(TYPE_STRING), 4);
    put_le(64'd2, 8); put_le(64'd1, 8); put(8'h00); put_le(64'd0, 8);
    put_str("ab"); put_le(64'd12, 4); put_le(64'hffff_ffff_ffff_ffff, 8);
    put_str(""); put_le(64'd10, 4); put_le(64'h0, 8);
    put_head(64'd2);
    put_str("x"); put_le(64'hffff_ffff, 4);
    put_head(64'd1);
    put_str("x"); put_le(64'(TYPE_ARRAY), 4); put_le(64'd13, 4);
    put_head(64'd65);
  endtask

  // Driver: presents pending bytes on push, holding each until it is taken.
  int send_gap = 0;
  always @(posedge clk) begin
    hdr_byte_t h;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) walk_byte(data_byte, first_byte);
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
          push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          h = pending_bytes.pop_front();
          push <= 1'b1;
          data_byte <= h.data;
          first_byte <= h.first;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops result words and checks each against the oldest expected word.
  int  pop_gap = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    rec_t got, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{kind, error_code, entry_number, entry_start, value_start, entry_end,
                value_type, element_type, element_count, tokenizer_key, last};
        words_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d mismatch: kind %0d/%0d err %0d/%0d num %0d/%0d start %h/%h vstart %h/%h end %h/%h vt %0d/%0d et %0d/%0d cnt %h/%h tok %0d/%0d last %0d/%0d",
                       words_seen, want.kind, got.kind, want.error_code, got.error_code,
                       want.entry_number, got.entry_number, want.entry_start, got.entry_start,
                       want.value_start, got.value_start, want.entry_end, got.entry_end,
                       want.value_type, got.value_type, want.element_type, got.element_type,
                       want.element_count, got.element_count, want.tokenizer_key,
                       got.tokenizer_key, want.last, got.last);
          end
        end
      end
      // Once, stop popping long enough for the block to fill and raise full.
      if (!long_hold_done && words_seen >= 40) begin
        long_hold_done = 1'b1;
        pop_gap = 400;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || push || expected_words.size() != 0);
    // Bytes that cause no word may still be inside the block.
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cap_entries = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] caps [5];
    restart_walk();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The reset value of the cap is used by the directed headers.
    put_directed();
    drain();
    caps = '{16'd0, 16'd65535, 16'd1, 16'($urandom_range(2, 65534)), 16'd64};
    foreach (caps[p]) begin
      write_cap(caps[p]);
      if (p == 4) idling_on = 1'b0;
      for (int n = 0; n < 160;) begin
        int before_sz;
        before_sz = pending_bytes.size();
        put_header();
        n += pending_bytes.size() - before_sz;
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
